// ----- rtl/lrfc_pkg.sv -----
// Shared types and constants for the lidar range filter and curvature block.
package lrfc_pkg;

  localparam int COORD_W = 20;
  localparam int CFG_W   = 16;
  localparam int LIM_W   = 2 * CFG_W;
  localparam int SQ_W    = 2 * COORD_W - 1;   // square of a 20-bit signed value
  localparam int RANGE_W = SQ_W + 2;          // sum of three squares
  localparam int CURV_W  = 50;
  localparam int IDX_W   = 18;

  localparam logic [CFG_W-1:0] MIN_RANGE_RESET = 16'd100;
  localparam logic [LIM_W-1:0] LIM_RESET =
    LIM_W'(MIN_RANGE_RESET) * LIM_W'(MIN_RANGE_RESET);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- rtl/lrfc_cell.sv -----
// One window cell: holds a point, loads its upstream neighbor on a shift and clears on clear.
module lrfc_cell (
  input  logic                clk,
  input  logic                rst,
  input  lrfc_pkg::cell_ctrl_t ctrl,
  input  lrfc_pkg::point_t    d,
  output lrfc_pkg::point_t    q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctrl.clear) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= d;
    end
  end

endmodule

// ----- rtl/lidar_range_filter_curvature_top.sv -----
// Top level: range filter, cell chain window and curvature pipeline.
// Stages: input, squares, range compare, snapshot, difference, squares, output.
// Throughput: one point per cycle unless stalled; cells shift once per kept point.
// Output stalls back up through the stage valids; bubbles are squeezed out.
// Reset (rst, synchronous): window cells, running sums, kept count and all
// stage valids clear; the minimum range returns to 100 mm.
module lidar_range_filter_curvature_top #(
  parameter int MAX_POINTS  = 262144,
  parameter int HALF_WINDOW = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [lrfc_pkg::CFG_W-1:0]          cfg_wdata,
  // point input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lrfc_pkg::COORD_W-1:0] pos_x,
  input  logic signed [lrfc_pkg::COORD_W-1:0] pos_y,
  input  logic signed [lrfc_pkg::COORD_W-1:0] pos_z,
  input  logic                                cloud_end,
  // curvature output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lrfc_pkg::CURV_W-1:0]         curvature,
  output logic [lrfc_pkg::IDX_W-1:0]          centre_index,
  output logic signed [lrfc_pkg::COORD_W-1:0] centre_x,
  output logic signed [lrfc_pkg::COORD_W-1:0] centre_y,
  output logic signed [lrfc_pkg::COORD_W-1:0] centre_z
);

  localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int IDXC_W  = (CNT_W > lrfc_pkg::IDX_W) ? CNT_W : lrfc_pkg::IDX_W;
  // running window sum of WIN_LEN coordinates
  localparam int WSUM_W  = lrfc_pkg::COORD_W + $clog2(WIN_LEN);
  // neighbor sum minus 2*HALF_WINDOW times centre, exact
  localparam int D_W     = lrfc_pkg::COORD_W + $clog2(4 * HALF_WINDOW);
  localparam int DSQ_W   = 2 * D_W;
  localparam int CSUM_W  = (DSQ_W + 2 > lrfc_pkg::CURV_W) ? DSQ_W + 2 : lrfc_pkg::CURV_W;

  // ---------------------------------------------------------------------
  // Stage enables. A stage loads when it is empty or its content moves on.
  // ---------------------------------------------------------------------
  logic v0, v1, v2, v3, v4, v5, v6;
  logic en0, en1, en2, en3, en4, en5, en6;

  assign en6 = !v6 || !out_stall;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign in_stall = !en0;

  // ---------------------------------------------------------------------
  // Squared minimum range, recomputed on each configuration write.
  // ---------------------------------------------------------------------
  logic [lrfc_pkg::LIM_W-1:0] range_lim_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_lim_sq <= lrfc_pkg::LIM_RESET;
    end else if (cfg_we) begin
      range_lim_sq <= lrfc_pkg::LIM_W'(cfg_wdata) * lrfc_pkg::LIM_W'(cfg_wdata);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: input register.
  // ---------------------------------------------------------------------
  lrfc_pkg::point_t s0_pt;
  logic             s0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_pt.x <= pos_x;
      s0_pt.y <= pos_y;
      s0_pt.z <= pos_z;
      s0_last <= cloud_end;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: per-axis squares for the range test.
  // ---------------------------------------------------------------------
  logic signed [2*lrfc_pkg::COORD_W-1:0] prod_x, prod_y, prod_z;
  logic [lrfc_pkg::SQ_W-1:0]             s1_sq_x, s1_sq_y, s1_sq_z;
  lrfc_pkg::point_t                      s1_pt;
  logic                                  s1_last;

  assign prod_x = (2*lrfc_pkg::COORD_W)'(s0_pt.x) * (2*lrfc_pkg::COORD_W)'(s0_pt.x);
  assign prod_y = (2*lrfc_pkg::COORD_W)'(s0_pt.y) * (2*lrfc_pkg::COORD_W)'(s0_pt.y);
  assign prod_z = (2*lrfc_pkg::COORD_W)'(s0_pt.z) * (2*lrfc_pkg::COORD_W)'(s0_pt.z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sq_x <= prod_x[lrfc_pkg::SQ_W-1:0];
      s1_sq_y <= prod_y[lrfc_pkg::SQ_W-1:0];
      s1_sq_z <= prod_z[lrfc_pkg::SQ_W-1:0];
      s1_pt   <= s0_pt;
      s1_last <= s0_last;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: range compare.
  // ---------------------------------------------------------------------
  logic [lrfc_pkg::RANGE_W-1:0] range_sq;
  logic                         s2_far;
  lrfc_pkg::point_t             s2_pt;
  logic                         s2_last;

  assign range_sq = lrfc_pkg::RANGE_W'(s1_sq_x) + lrfc_pkg::RANGE_W'(s1_sq_y)
                  + lrfc_pkg::RANGE_W'(s1_sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_far  <= (range_sq >= lrfc_pkg::RANGE_W'(range_lim_sq));
      s2_pt   <= s1_pt;
      s2_last <= s1_last;
    end
  end

  // ---------------------------------------------------------------------
  // Window: a chain of cells, oldest point in cell 0, newest in the last.
  // Running per-axis sums of all cells avoid a wide adder tree; the centre
  // term is folded in downstream.
  // ---------------------------------------------------------------------
  logic                         take;      // stage 2 transaction moves into stage 3
  logic [CNT_W-1:0]             kept_count;
  logic                         keep;
  logic                         emit;
  logic                         sweep_clr;
  lrfc_pkg::cell_ctrl_t         cell_ctrl;
  lrfc_pkg::point_t             cell_q  [WIN_LEN];
  lrfc_pkg::point_t             cell_d  [WIN_LEN];
  logic signed [WSUM_W-1:0]     wsum_x, wsum_y, wsum_z;
  logic signed [WSUM_W-1:0]     wsum_x_next, wsum_y_next, wsum_z_next;
  logic [IDXC_W-1:0]            idx_calc;

  assign take      = v2 && en3;
  assign keep      = take && s2_far && (kept_count < CNT_W'(MAX_POINTS));
  // count before this point is at least 2*HALF_WINDOW: window fills with it
  assign emit      = keep && (kept_count >= CNT_W'(WIN_LEN - 1));
  assign sweep_clr = take && s2_last;

  assign cell_ctrl.shift = keep;
  assign cell_ctrl.clear = sweep_clr;

  genvar gi;
  generate
    for (gi = 0; gi < WIN_LEN; gi++) begin : g_cell
      if (gi == WIN_LEN - 1) begin : g_tail
        assign cell_d[gi] = s2_pt;
      end else begin : g_body
        assign cell_d[gi] = cell_q[gi+1];
      end
      lrfc_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctrl (cell_ctrl),
        .d    (cell_d[gi]),
        .q    (cell_q[gi])
      );
    end
  endgenerate

  // sum after the shift: new point in, oldest point out
  assign wsum_x_next = wsum_x + WSUM_W'(s2_pt.x) - WSUM_W'(cell_q[0].x);
  assign wsum_y_next = wsum_y + WSUM_W'(s2_pt.y) - WSUM_W'(cell_q[0].y);
  assign wsum_z_next = wsum_z + WSUM_W'(s2_pt.z) - WSUM_W'(cell_q[0].z);

  // centre index = kept count after this point - 1 - HALF_WINDOW
  assign idx_calc = IDXC_W'(kept_count) - IDXC_W'(HALF_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      wsum_x     <= '0;
      wsum_y     <= '0;
      wsum_z     <= '0;
    end else if (sweep_clr) begin
      kept_count <= '0;
      wsum_x     <= '0;
      wsum_y     <= '0;
      wsum_z     <= '0;
    end else if (keep) begin
      kept_count <= kept_count + CNT_W'(1);
      wsum_x     <= wsum_x_next;
      wsum_y     <= wsum_y_next;
      wsum_z     <= wsum_z_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: snapshot of the window sum and centre after the shift, taken
  // before a sweep end clears the chain.
  // ---------------------------------------------------------------------
  logic signed [WSUM_W-1:0]    s3_sum_x, s3_sum_y, s3_sum_z;
  lrfc_pkg::point_t            s3_c;
  logic [lrfc_pkg::IDX_W-1:0]  s3_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sum_x <= wsum_x_next;
      s3_sum_y <= wsum_y_next;
      s3_sum_z <= wsum_z_next;
      s3_c     <= cell_q[HALF_WINDOW+1];
      s3_idx   <= idx_calc[lrfc_pkg::IDX_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: difference vector. Neighbor sum - 2H*c == window sum - (2H+1)*c.
  // ---------------------------------------------------------------------
  logic signed [D_W-1:0]       d_x, d_y, d_z;
  logic signed [D_W-1:0]       s4_d_x, s4_d_y, s4_d_z;
  lrfc_pkg::point_t            s4_c;
  logic [lrfc_pkg::IDX_W-1:0]  s4_idx;

  assign d_x = D_W'(s3_sum_x) - D_W'(s3_c.x) * D_W'(WIN_LEN);
  assign d_y = D_W'(s3_sum_y) - D_W'(s3_c.y) * D_W'(WIN_LEN);
  assign d_z = D_W'(s3_sum_z) - D_W'(s3_c.z) * D_W'(WIN_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_d_x <= d_x;
      s4_d_y <= d_y;
      s4_d_z <= d_z;
      s4_c   <= s3_c;
      s4_idx <= s3_idx;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: squares of the difference components.
  // ---------------------------------------------------------------------
  logic signed [DSQ_W-1:0]     dsq_x, dsq_y, dsq_z;
  logic [DSQ_W-1:0]            s5_sq_x, s5_sq_y, s5_sq_z;
  lrfc_pkg::point_t            s5_c;
  logic [lrfc_pkg::IDX_W-1:0]  s5_idx;

  assign dsq_x = DSQ_W'(s4_d_x) * DSQ_W'(s4_d_x);
  assign dsq_y = DSQ_W'(s4_d_y) * DSQ_W'(s4_d_y);
  assign dsq_z = DSQ_W'(s4_d_z) * DSQ_W'(s4_d_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_sq_x <= dsq_x;
      s5_sq_y <= dsq_y;
      s5_sq_z <= dsq_z;
      s5_c    <= s4_c;
      s5_idx  <= s4_idx;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: output register, squared norm.
  // ---------------------------------------------------------------------
  logic [CSUM_W-1:0]           curv_sum;
  logic [lrfc_pkg::CURV_W-1:0] s6_curv;
  lrfc_pkg::point_t            s6_c;
  logic [lrfc_pkg::IDX_W-1:0]  s6_idx;

  assign curv_sum = CSUM_W'(s5_sq_x) + CSUM_W'(s5_sq_y) + CSUM_W'(s5_sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_curv <= curv_sum[lrfc_pkg::CURV_W-1:0];
      s6_c    <= s5_c;
      s6_idx  <= s5_idx;
    end
  end

  assign out_valid    = v6;
  assign curvature    = s6_curv;
  assign centre_index = s6_idx;
  assign centre_x     = s6_c.x;
  assign centre_y     = s6_c.y;
  assign centre_z     = s6_c.z;

endmodule

// ----- rtl/lrfc_checker.sv -----
// Port-level checks for the curvature block, bound to the top level.
module lrfc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [lrfc_pkg::CURV_W-1:0]         curvature,
  input logic [lrfc_pkg::IDX_W-1:0]          centre_index
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(curvature) && $stable(centre_index))
    else $error("stalled result changed");

  // input only stalls under back-pressure from a held result
  a_no_free_stall: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled without output back-pressure");

  // a full window plus the pipeline cannot produce a result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result shortly after reset");

endmodule

bind lidar_range_filter_curvature_top lrfc_checker u_lrfc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .curvature    (curvature),
  .centre_index (centre_index)
);

// ----- test/tb_lidar_range_filter_curvature_top.sv -----
// Testbench for the lidar range filter and curvature block: random and directed sweeps.
module tb_lidar_range_filter_curvature_top;

  localparam int COORD_W = lrfc_pkg::COORD_W;
  localparam int CFG_W   = lrfc_pkg::CFG_W;
  localparam int CURV_W  = lrfc_pkg::CURV_W;
  localparam int IDX_W   = lrfc_pkg::IDX_W;

  // Window geometry and sweep limit, tied to the instance below.
  localparam int HALF      = 5;
  localparam int WIN       = 2 * HALF + 1;
  localparam int MAX_PTS   = 262144;
  // Cycles to let the pipeline settle once nothing more is expected.
  localparam int DRAIN_CYC = 20;
  // Receiver hold-off used once to back the block up into its input.
  localparam int HOLD_CYC  = 300;
  // Watchdog: cycles with no transaction on either channel.
  localparam int WATCH_LIM = 4000;
  localparam int Q_CAP     = 64;

  localparam logic signed [COORD_W-1:0] C_MAX = 20'sh7FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 20'sh80000;

  typedef enum int {PK_FULL, PK_SMALL, PK_EDGE, PK_EXTREME} point_kind_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } point_item_t;

  typedef struct {
    logic [CURV_W-1:0]         curv;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } curv_result_t;

  // DUT-facing signals; every input starts at a known value.
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_W-1:0]          cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] pos_x = '0;
  logic signed [COORD_W-1:0] pos_y = '0;
  logic signed [COORD_W-1:0] pos_z = '0;
  logic                      cloud_end = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [CURV_W-1:0]         curvature;
  logic [IDX_W-1:0]          centre_index;
  logic signed [COORD_W-1:0] centre_x;
  logic signed [COORD_W-1:0] centre_y;
  logic signed [COORD_W-1:0] centre_z;

  lidar_range_filter_curvature_top #(
    .MAX_POINTS (MAX_PTS),
    .HALF_WINDOW(HALF)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .cloud_end   (cloud_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .curvature   (curvature),
    .centre_index(centre_index),
    .centre_x    (centre_x),
    .centre_y    (centre_y),
    .centre_z    (centre_z)
  );

  // Point stream waiting for the driver, and curvature results still owed.
  point_item_t  point_q[$];
  curv_result_t curv_q[$];
  int           err_cnt = 0;

  // Shadow of the block: kept-point window (oldest at 0), kept count and
  // the minimum range register.
  longint           win_c [WIN][3];
  int               kept_n = 0;
  logic [CFG_W-1:0] min_mm = lrfc_pkg::MIN_RANGE_RESET;

  // Idling controls, written by the sequencer on falling edges only.
  bit drv_gap_en   = 1'b1;
  bit rcv_stall_en = 1'b1;
  int hold_ask     = 0;

  logic signed [COORD_W-1:0] ext_vals [4] = '{C_MAX, C_MIN, 20'sd0, -20'sd1};

  initial begin
    forever #6 clk = ~clk;
  end

  // Mostly no gap, some short, a few long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one accepted point to the shadow and queue the result it causes.
  task automatic model_point(input point_item_t it);
    longint       p [3];
    longint       r2, lim2, d, cv;
    int           a, k;
    curv_result_t res;
    p[0] = it.x;
    p[1] = it.y;
    p[2] = it.z;
    r2   = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
    lim2 = longint'(min_mm) * longint'(min_mm);
    // Too close, or the sweep is already full: the point is dropped.
    if (r2 >= lim2 && kept_n < MAX_PTS) begin
      for (k = 0; k < WIN - 1; k++) begin
        for (a = 0; a < 3; a++) win_c[k][a] = win_c[k+1][a];
      end
      for (a = 0; a < 3; a++) win_c[WIN-1][a] = p[a];
      kept_n++;
      // A centre needs HALF kept neighbours on each side.
      if (kept_n >= WIN) begin
        cv = 0;
        for (a = 0; a < 3; a++) begin
          d = -2 * HALF * win_c[HALF][a];
          for (k = 0; k < WIN; k++) begin
            if (k != HALF) d += win_c[k][a];
          end
          cv += d * d;
        end
        res.curv = CURV_W'(cv);
        res.idx  = IDX_W'(kept_n - 1 - HALF);
        res.x    = COORD_W'(win_c[HALF][0]);
        res.y    = COORD_W'(win_c[HALF][1]);
        res.z    = COORD_W'(win_c[HALF][2]);
        curv_q.insert(curv_q.size(), res);
      end
    end
    // End of sweep clears window and count, kept or not.
    if (it.last) begin
      for (k = 0; k < WIN; k++) begin
        for (a = 0; a < 3; a++) win_c[k][a] = 0;
      end
      kept_n = 0;
    end
  endtask

  // Driver: holds the payload while stalled, inserts random gaps between
  // transactions and models each point the moment it is accepted.
  point_item_t drv_item;
  int          gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) model_point(drv_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (point_q.size() > 0) begin
          drv_item = point_q.pop_front();
          pos_x     <= drv_item.x;
          pos_y     <= drv_item.y;
          pos_z     <= drv_item.z;
          cloud_end <= drv_item.last;
          in_valid  <= 1'b1;
          gap_left = drv_gap_en ? pick_idle() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic bit field_bad(input string nm, input logic signed [63:0] want,
                                   input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Monitor: checks each accepted result against the oldest one owed, and
  // drives the receiver stall (random runs plus the one long hold-off).
  int hold_taken = 0;
  int hold_left  = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    curv_result_t want;
    bit           bad;
    if (!rst && out_valid && !out_stall) begin
      if (curv_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got index %0d curvature %0d",
                 $time, centre_index, curvature);
        err_cnt++;
      end else begin
        want = curv_q.pop_front();
        bad  = field_bad("curvature", want.curv, curvature)
             | field_bad("centre_index", want.idx, centre_index)
             | field_bad("centre_x", want.x, centre_x)
             | field_bad("centre_y", want.y, centre_y)
             | field_bad("centre_z", want.z, centre_z);
        if (bad) err_cnt++;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_taken != hold_ask) begin
      hold_taken++;
      hold_left = HOLD_CYC - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rcv_stall_en && $urandom_range(0, 3) == 0) begin
      stall_left = pick_idle();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any transaction.
  int quiet_cyc = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cyc = 0;
    end else begin
      quiet_cyc++;
      if (quiet_cyc >= WATCH_LIM) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCH_LIM, curv_q.size());
        $display("tb_lidar_range_filter_curvature_top: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers. The sequencer only touches queues and idling controls
  // on falling edges, so the clocked processes never race with it.
  // ---------------------------------------------------------------------

  task automatic push_point(input point_item_t p);
    while (point_q.size() >= Q_CAP) @(negedge clk);
    point_q.insert(point_q.size(), p);
  endtask

  task automatic push_xyz(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                          input logic signed [COORD_W-1:0] z, input logic last);
    point_item_t p;
    p.x    = x;
    p.y    = y;
    p.z    = z;
    p.last = last;
    push_point(p);
  endtask

  function automatic point_item_t make_point(input point_kind_t kind, input logic [CFG_W-1:0] mn);
    point_item_t p;
    int          v;
    p.x    = COORD_W'($urandom);
    p.y    = COORD_W'($urandom);
    p.z    = COORD_W'($urandom);
    p.last = 1'b0;
    case (kind)
      PK_SMALL: begin
        // Close-in clutter; mostly dropped once the range limit is large.
        v = $urandom_range(0, 4000); p.x = COORD_W'(v - 2000);
        v = $urandom_range(0, 4000); p.y = COORD_W'(v - 2000);
        v = $urandom_range(0, 4000); p.z = COORD_W'(v - 2000);
      end
      PK_EDGE: begin
        // On one axis, exactly at the limit or one mm inside it.
        v = int'(mn) - int'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) v = -v;
        p.x = '0;
        p.y = '0;
        p.z = '0;
        case ($urandom_range(0, 2))
          0:       p.x = COORD_W'(v);
          1:       p.y = COORD_W'(v);
          default: p.z = COORD_W'(v);
        endcase
      end
      PK_EXTREME: begin
        p.x = ext_vals[$urandom_range(0, 3)];
        p.y = ext_vals[$urandom_range(0, 3)];
        p.z = ext_vals[$urandom_range(0, 3)];
      end
      default: ;
    endcase
    return p;
  endfunction

  // One sweep of n points closed by cloud_end; now and then an early
  // cloud_end breaks the sweep in the middle.
  task automatic push_sweep(input int n);
    point_item_t p;
    point_kind_t kind;
    int          i, r;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      kind = (r < 50) ? PK_FULL : (r < 75) ? PK_SMALL : (r < 90) ? PK_EDGE : PK_EXTREME;
      p = make_point(kind, min_mm);
      p.last = (i == n - 1) || ($urandom_range(0, 99) == 0);
      push_point(p);
    end
  endtask

  // Mostly sweeps long enough to produce centres, some too short for any.
  task automatic run_random(input int n_items);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 99) < 80) ? $urandom_range(WIN, 40) : $urandom_range(1, WIN - 1);
      if (len > left) len = left;
      push_sweep(len);
      left -= len;
    end
  endtask

  // Everything sent, every result in, then a pause for dropped points
  // still in flight. Ends on a falling edge.
  task automatic wait_idle();
    @(negedge clk);
    while (point_q.size() != 0 || in_valid || curv_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_min(input logic [CFG_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_mm = v;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] min_plan [10];
  int               i, j;

  initial begin
    for (i = 0; i < WIN; i++) begin
      for (j = 0; j < 3; j++) win_c[i][j] = 0;
    end
    min_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd100, 16'd2000, 16'd0, 16'hFFFF, 16'd0, 16'd0};
    min_plan[3] = CFG_W'($urandom_range(0, 65535));
    min_plan[6] = CFG_W'($urandom_range(0, 65535));
    min_plan[8] = CFG_W'($urandom_range(0, 65535));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset limit of 100 mm.
    // Largest curvature: a most-negative centre among most-positive
    // neighbours; the kept final point yields its result before the clear.
    for (i = 0; i < WIN; i++) begin
      if (i == HALF) push_xyz(C_MIN, C_MIN, C_MIN, 1'b0);
      else           push_xyz(C_MAX, C_MAX, C_MAX, i == WIN - 1);
    end
    // Range threshold: at the limit is kept, inside it is dropped.
    push_xyz(20'sd0, 20'sd0, 20'sd0, 1'b0);
    push_xyz(20'sd99, 20'sd0, 20'sd0, 1'b0);
    push_xyz(20'sd100, 20'sd0, 20'sd0, 1'b0);
    push_xyz(20'sd0, -20'sd100, 20'sd0, 1'b0);
    push_xyz(20'sd0, 20'sd0, 20'sd100, 1'b0);
    push_xyz(20'sd57, 20'sd57, 20'sd57, 1'b0);
    push_xyz(20'sd58, -20'sd58, 20'sd58, 1'b0);
    push_xyz(C_MIN, C_MIN, C_MIN, 1'b0);
    push_xyz(C_MAX, C_MIN, 20'sd0, 1'b0);
    push_xyz(20'sd1000, 20'sd2000, -20'sd3000, 1'b0);
    push_xyz(C_MIN, 20'sd0, 20'sd0, 1'b0);
    push_xyz(20'sd0, C_MAX, 20'sd0, 1'b0);
    push_xyz(20'sd0, 20'sd0, C_MIN, 1'b0);
    push_xyz(C_MAX, C_MAX, C_MAX, 1'b0);
    // Sweep closed by a dropped point: still clears the window.
    push_xyz(20'sd0, 20'sd0, 20'sd0, 1'b1);

    // Random phases across range limits, extremes among them.
    for (i = 0; i < 10; i++) begin
      write_min(min_plan[i]);
      if (i == 4) begin
        // Back-pressure: the receiver holds off while the sender streams.
        drv_gap_en   = 1'b0;
        rcv_stall_en = 1'b0;
        hold_ask++;
      end else begin
        drv_gap_en   = ($urandom_range(0, 3) != 0);
        rcv_stall_en = ($urandom_range(0, 3) != 0);
      end
      run_random(120);
    end

    // A last phase with a random limit.
    write_min(CFG_W'($urandom_range(0, 65535)));
    drv_gap_en   = 1'b1;
    rcv_stall_en = 1'b1;
    run_random(60);

    wait_idle();
    if (err_cnt == 0) begin
      $display("tb_lidar_range_filter_curvature_top: clean");
    end else begin
      $display("tb_lidar_range_filter_curvature_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lrfc_pkg.sv
rtl/lrfc_cell.sv
rtl/lidar_range_filter_curvature_top.sv
rtl/lrfc_checker.sv
test/tb_lidar_range_filter_curvature_top.sv
